>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion shorthands
// Implication checks under an active-low asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define LGS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("lbl failed");

// Next-cycle implication
`define LGS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("lbl failed");

`endif

>>> sv/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg - life grid step shared definitions
// Operation codes, register indexes, field widths and cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package lgs_pkg;

	localparam int unsigned DEF_MAX_ROWS = 64;
	localparam int unsigned DEF_MAX_COLS = 64;

	localparam int unsigned OP_W   = 2;
	localparam int unsigned IDX_W  = 6;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned CFG_W  = 7;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_W-1:0] ROWS_RST = 7'd5;
	localparam logic [CFG_W-1:0] COLS_RST = 7'd5;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_READ    = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} reg_idx_t;

	// Broadcast control from the top level to every row cell
	typedef struct packed {
		logic             load;
		logic             advance;
		logic [IDX_W-1:0] idx;
	} cell_ctl_t;

endpackage

`default_nettype wire

>>> sv/lgs_in_if.sv
// ----------------------------------------------------------------------------
// lgs_in_if - command channel
// Valid/ready channel carrying one grid operation per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgs_in_if import lgs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [IDX_W-1:0]  row_index;
	logic [DATA_W-1:0] row_cells;

	modport source (output valid, operation, row_index, row_cells, input ready);
	modport sink   (input valid, operation, row_index, row_cells, output ready);
endinterface

`default_nettype wire

>>> sv/lgs_out_if.sv
// ----------------------------------------------------------------------------
// lgs_out_if - read result channel
// Valid/ready channel carrying one row read back per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lgs_out_if import lgs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  read_index;
	logic [DATA_W-1:0] read_cells;

	modport source (output valid, read_index, read_cells, input ready);
	modport sink   (input valid, read_index, read_cells, output ready);
endinterface

`default_nettype wire

>>> sv/lgs_row_cell.sv
// ----------------------------------------------------------------------------
// lgs_row_cell - one grid row
// Holds one row of cells, computes its next generation from the rows above
// and below, and forwards the read token down the chain of rows.
// ----------------------------------------------------------------------------
`default_nettype none

module lgs_row_cell import lgs_pkg::*; #(
	parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
	parameter int unsigned MAX_COLS = DEF_MAX_COLS,
	parameter int unsigned CELL_ID  = 0
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cell_ctl_t                     ctl,
	input  wire logic [MAX_COLS-1:0]           load_row,
	input  wire logic [$clog2(MAX_ROWS+1)-1:0] rows_lim,
	input  wire logic [MAX_COLS-1:0]           region,
	input  wire logic [MAX_COLS-1:0]           above,
	input  wire logic [MAX_COLS-1:0]           below,
	output logic      [MAX_COLS-1:0]           row,
	input  wire logic                          rd_v_in,
	input  wire logic [MAX_COLS-1:0]           rd_d_in,
	output logic                               rd_v,
	output logic      [MAX_COLS-1:0]           rd_d
);

	logic [MAX_COLS-1:0] row_q;
	logic                rd_v_q;
	logic [MAX_COLS-1:0] rd_d_q;

	logic                hit;
	logic                active;
	logic                has_below;
	logic [MAX_COLS-1:0] up_m, mid_m, dn_m;
	logic [MAX_COLS+1:0] up_x, mid_x, dn_x;
	logic [MAX_COLS-1:0] fresh;
	logic [MAX_COLS-1:0] next_row;
	logic [3:0]          n;

	// Decode row address and evolution region
	assign hit       = {{(32-IDX_W){1'b0}}, ctl.idx} == CELL_ID;
	assign active    = CELL_ID < 32'(rows_lim);
	assign has_below = (CELL_ID + 1) < 32'(rows_lim);

	// Mask neighbours outside the region as dead
	assign up_m  = above & region;
	assign mid_m = row_q & region;
	assign dn_m  = has_below ? (below & region) : '0;

	// Pad one dead column on each side: column c sits at bit c + 1
	assign up_x  = {1'b0, up_m, 1'b0};
	assign mid_x = {1'b0, mid_m, 1'b0};
	assign dn_x  = {1'b0, dn_m, 1'b0};

	// Count eight neighbours per column and apply birth/survival rule
	always_comb begin
		fresh = '0;
		n     = '0;
		for (int c = 0; c < MAX_COLS; c++) begin
			n = 4'(up_x[c]) + 4'(up_x[c+1]) + 4'(up_x[c+2])
				+ 4'(mid_x[c]) + 4'(mid_x[c+2])
				+ 4'(dn_x[c]) + 4'(dn_x[c+1]) + 4'(dn_x[c+2]);
			fresh[c] = (n == 4'd3) || (mid_m[c] && (n == 4'd2));
		end
	end

	assign next_row = (row_q & ~region) | (fresh & region);

	// Hold row: load by address, advance when inside the region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (ctl.load && hit) begin
			row_q <= load_row;
		end else if (ctl.advance && active) begin
			row_q <= next_row;
		end
	end

	// Pass the read token one row per cycle, merging this row on a match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
		end else begin
			rd_v_q <= rd_v_in;
		end
	end

	always_ff @(posedge clk) begin
		rd_d_q <= rd_d_in | (hit ? row_q : '0);
	end

	assign row  = row_q;
	assign rd_v = rd_v_q;
	assign rd_d = rd_d_q;

endmodule

`default_nettype wire

>>> sv/life_grid_generation_step.sv
// ----------------------------------------------------------------------------
// life_grid_generation_step - life grid, birth on 3, survival on 2 or 3
// Chain of row cells holding the grid, with command, result and config ports.
// ----------------------------------------------------------------------------
// A load writes one row cell, and an advance updates every row cell inside
// the region at once from the old grid. A read sends a token down the chain
// of MAX_ROWS row cells, one cell per cycle, once the previous result has
// been taken; the result register loads when the token leaves the last
// cell, and no command is accepted until the read completes. Loads and
// advances keep flowing while a result waits. rows_in_use and cols_in_use
// are to be written only while the block is idle, which the block does not
// enforce; 0 acts as 1 and values above MAX_ROWS / MAX_COLS saturate. The
// grid is all dead after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module life_grid_generation_step import lgs_pkg::*; #(
	parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
	parameter int unsigned MAX_COLS = DEF_MAX_COLS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	lgs_in_if.sink                    cmd,
	lgs_out_if.source                 rsp
);

	localparam int unsigned RCW = $clog2(MAX_ROWS + 1);

	logic [CFG_W-1:0]    rows_q, cols_q;
	logic [RCW-1:0]      rows_lim;
	logic [CFG_W-1:0]    cols_lim;
	logic [MAX_COLS-1:0] region;

	logic                pend_q, fly_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic                out_v_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [DATA_W-1:0]   out_cells_q;

	logic                acc, launch, arrive;
	cell_ctl_t           ctl;

	logic [MAX_COLS-1:0] row_w [MAX_ROWS];
	logic                rdv_w [MAX_ROWS];
	logic [MAX_COLS-1:0] rdd_w [MAX_ROWS];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROWS: rows_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// Clamp region size: zero acts as one, saturate at the grid size
	always_comb begin
		if (rows_q == '0) begin
			rows_lim = RCW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			rows_lim = RCW'(MAX_ROWS);
		end else begin
			rows_lim = RCW'(rows_q);
		end
		if (cols_q == '0) begin
			cols_lim = CFG_W'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			cols_lim = CFG_W'(MAX_COLS);
		end else begin
			cols_lim = cols_q;
		end
	end

	// Build the column mask of the region
	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			region[c] = c < 32'(cols_lim);
		end
	end

	// Accept and decode a command transaction
	assign cmd.ready = !pend_q && !fly_q;
	assign acc       = cmd.valid && cmd.ready;
	assign launch    = pend_q && !out_v_q;
	assign arrive    = rdv_w[MAX_ROWS-1];

	always_comb begin
		ctl.load    = acc && (cmd.operation == OP_LOAD);
		ctl.advance = acc && (cmd.operation == OP_ADVANCE);
		ctl.idx     = (pend_q || fly_q) ? rd_idx_q : cmd.row_index;
	end

	// Track a read: wait for a free result register, then run the token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			fly_q  <= 1'b0;
		end else begin
			if (acc && (cmd.operation == OP_READ)) begin
				pend_q <= 1'b1;
			end else if (launch) begin
				pend_q <= 1'b0;
			end
			if (launch) begin
				fly_q <= 1'b1;
			end else if (arrive) begin
				fly_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && (cmd.operation == OP_READ)) begin
			rd_idx_q <= cmd.row_index;
		end
	end

	// Chain of row cells
	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_row
		logic [MAX_COLS-1:0] up, dn, rd_in;
		logic                rdv_in;

		if (i == 0) begin : g_first
			assign up     = '0;
			assign rdv_in = launch;
			assign rd_in  = '0;
		end else begin : g_next
			assign up     = row_w[i-1];
			assign rdv_in = rdv_w[i-1];
			assign rd_in  = rdd_w[i-1];
		end

		if (i == MAX_ROWS - 1) begin : g_last
			assign dn = '0;
		end else begin : g_mid
			assign dn = row_w[i+1];
		end

		lgs_row_cell #(
			.MAX_ROWS (MAX_ROWS),
			.MAX_COLS (MAX_COLS),
			.CELL_ID  (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.load_row (cmd.row_cells[MAX_COLS-1:0]),
			.rows_lim (rows_lim),
			.region   (region),
			.above    (up),
			.below    (dn),
			.row      (row_w[i]),
			.rd_v_in  (rdv_in),
			.rd_d_in  (rd_in),
			.rd_v     (rdv_w[i]),
			.rd_d     (rdd_w[i])
		);
	end

	// Result register: load on token arrival, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (arrive) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (arrive) begin
			out_idx_q   <= rd_idx_q;
			out_cells_q <= DATA_W'(rdd_w[MAX_ROWS-1]);
		end
	end

	assign rsp.valid      = out_v_q;
	assign rsp.read_index = out_idx_q;
	assign rsp.read_cells = out_cells_q;

	// Checks
	`LGS_ASSERT_IMP(a_pend_fly_excl, clk, arst_n, pend_q, !fly_q)
	`LGS_ASSERT_IMP(a_fly_out_empty, clk, arst_n, fly_q, !out_v_q)
	`LGS_ASSERT_IMP(a_arrive_in_fly, clk, arst_n, arrive, fly_q)
	`LGS_ASSERT_NXT(a_read_blocks, clk, arst_n, acc && (cmd.operation == OP_READ), !cmd.ready)

endmodule

`default_nettype wire
